// File: design/fam_pkg.sv
// Shared types, widths and state codes for the exact fraction unit.
// Used by every module of the block; depends on nothing else.
package fam_pkg;

    localparam int OPERAND_BITS = 16;
    localparam int PROD_W       = 2 * OPERAND_BITS;
    // Sums of two products grow by one bit but are kept within 64 bits.
    localparam int SUM_W        = (2 * OPERAND_BITS + 1 > 64) ? 64 : 2 * OPERAND_BITS + 1;
    localparam int DIV_CNT_W    = $clog2(SUM_W + 1);

    localparam int FIELD_W   = 16;
    localparam int WIDE_W    = 32;
    localparam int WIDER_W   = 33;

    typedef enum logic [1:0] {
        REQ_SIMPLIFY = 2'd0,
        REQ_MULTIPLY = 2'd1,
        REQ_ADD      = 2'd2,
        REQ_ADD_ALT  = 2'd3
    } req_type_t;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [FIELD_W-1:0] num1;
        logic [FIELD_W-1:0] den1;
        logic [FIELD_W-1:0] num2;
        logic [FIELD_W-1:0] den2;
    } fam_req_t;

    typedef struct packed {
        logic [WIDE_W-1:0]  expanded_left;
        logic [WIDE_W-1:0]  expanded_right;
        logic [WIDER_W-1:0] raw_numerator;
        logic [WIDE_W-1:0]  raw_denominator;
        logic [WIDER_W-1:0] reduced_numerator;
        logic [WIDE_W-1:0]  reduced_denominator;
        logic               is_whole;
    } fam_res_t;

    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] dividend;
        logic [SUM_W-1:0] divisor;
    } div_cmd_t;

    typedef struct packed {
        logic             done;
        logic [SUM_W-1:0] quot;
        logic [SUM_W-1:0] rem;
    } div_rsp_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_GCD_D,
        S_DIV_Q1,
        S_DIV_S1,
        S_MUL_L,
        S_MUL_XL,
        S_MUL_XR,
        S_ADD_SUM,
        S_MUL_N,
        S_MUL_D,
        S_MUL_FIN,
        S_DIV_W,
        S_GCD_R,
        S_DIV_RN,
        S_DIV_RD,
        S_DONE
    } fam_state_t;

endpackage

// File: design/fam_div.sv
// Shared restoring divider: one quotient bit per cycle, gives quotient and remainder.
// Depends on fam_pkg for the operand width and the command and response structs.
module fam_div (
    input  logic              clk,
    input  logic              rst_n,
    input  fam_pkg::div_cmd_t cmd,
    output fam_pkg::div_rsp_t rsp
);
    import fam_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [SUM_W-1:0]     rem_reg, rem_next;
    logic [SUM_W-1:0]     quot_reg, quot_next;
    logic [SUM_W-1:0]     dvs_reg, dvs_next;
    logic [SUM_W:0]       trial;
    logic                 fits;

    assign trial = {rem_reg, quot_reg[SUM_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        dvs_next  = dvs_reg;
        if (cmd.start && !busy_reg)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(SUM_W);
            rem_next  = '0;
            quot_next = cmd.dividend;
            dvs_next  = cmd.divisor;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_next = SUM_W'(trial - {1'b0, dvs_reg});
            end
            else
            begin
                rem_next = trial[SUM_W-1:0];
            end
            quot_next = {quot_reg[SUM_W-2:0], fits};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        dvs_reg  <= dvs_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;
    assign rsp.rem  = rem_reg;

endmodule

// File: design/fam_mul.sv
// Shared operand multiplier with a registered product.
// Depends on fam_pkg for the operand and product widths.
module fam_mul (
    input  logic                                clk,
    input  logic [fam_pkg::OPERAND_BITS-1:0]    a,
    input  logic [fam_pkg::OPERAND_BITS-1:0]    b,
    output logic [fam_pkg::PROD_W-1:0]          p
);
    import fam_pkg::*;

    logic [PROD_W-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= PROD_W'(a) * PROD_W'(b);
    end

    assign p = p_reg;

endmodule

// File: design/fraction_add_multiply_reduce_top.sv
// Exact fraction unit: sequencer and datapath around a shared divider and multiplier.
// Depends on fam_pkg, fam_div and fam_mul.
//
//   channel   | ports                  | handshake
//   ----------+------------------------+-----------------------------------------
//   request   | start, request, busy   | taken when start is high and busy is low
//   result    | done, result           | one-cycle strobe, cannot be held off
//
// The time a request takes grows with N, the number of Euclid steps in its gcd searches, as
// each step is a divide on the shared bit-serial divider, and these divides dominate the time.
// Busy stays high from acceptance until the result strobe. Reset clears the sequencer and the
// divider control only; no clearing pass is needed.
module fraction_add_multiply_reduce_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  fam_pkg::fam_req_t request,
    output logic              busy,
    output logic              done,
    output fam_pkg::fam_res_t result
);
    import fam_pkg::*;

    fam_state_t state_reg, state_next;
    logic       wait_reg, wait_next;

    logic [OPERAND_BITS-1:0] n1_reg, d1_reg, n2_reg, d2_reg;
    logic [OPERAND_BITS-1:0] q1_reg, s1_reg;
    logic [SUM_W-1:0]        a_reg, b_reg;
    logic [PROD_W-1:0]       l_reg, exl_reg, exr_reg;
    logic [SUM_W-1:0]        rn_reg, rd_reg, qn_reg, qd_reg;
    logic                    whole_reg;

    logic [OPERAND_BITS-1:0] in_n1, in_d1, in_n2, in_d2;
    logic                    accept;
    logic                    div_state;

    div_cmd_t                div_cmd;
    div_rsp_t                div_rsp;
    logic [OPERAND_BITS-1:0] mul_a, mul_b;
    logic [PROD_W-1:0]       mul_p;

    fam_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (div_cmd),
        .rsp   (div_rsp)
    );

    fam_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;

    assign in_n1 = OPERAND_BITS'(request.num1);
    assign in_n2 = OPERAND_BITS'(request.num2);
    // A zero denominator is taken as one.
    assign in_d1 = (OPERAND_BITS'(request.den1) == '0) ? OPERAND_BITS'(1)
                                                       : OPERAND_BITS'(request.den1);
    assign in_d2 = (OPERAND_BITS'(request.den2) == '0) ? OPERAND_BITS'(1)
                                                       : OPERAND_BITS'(request.den2);

    assign div_state = (state_reg == S_GCD_D) || (state_reg == S_DIV_Q1) ||
                       (state_reg == S_DIV_S1) || (state_reg == S_DIV_W) ||
                       (state_reg == S_GCD_R) || (state_reg == S_DIV_RN) ||
                       (state_reg == S_DIV_RD);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (request.req_type)
                        REQ_SIMPLIFY: state_next = S_DIV_W;
                        REQ_MULTIPLY: state_next = S_MUL_N;
                        default:      state_next = S_GCD_D;
                    endcase
                end
            end
            S_GCD_D:
            begin
                if (!wait_reg && b_reg == '0)
                begin
                    state_next = S_DIV_Q1;
                end
            end
            S_DIV_Q1:  if (wait_reg && div_rsp.done) state_next = S_DIV_S1;
            S_DIV_S1:  if (wait_reg && div_rsp.done) state_next = S_MUL_L;
            S_MUL_L:   state_next = S_MUL_XL;
            S_MUL_XL:  state_next = S_MUL_XR;
            S_MUL_XR:  state_next = S_ADD_SUM;
            S_ADD_SUM: state_next = S_DIV_W;
            S_MUL_N:   state_next = S_MUL_D;
            S_MUL_D:   state_next = S_MUL_FIN;
            S_MUL_FIN: state_next = S_DIV_W;
            S_DIV_W:
            begin
                if (wait_reg && div_rsp.done)
                begin
                    state_next = (div_rsp.rem == '0) ? S_DONE : S_GCD_R;
                end
            end
            S_GCD_R:
            begin
                if (!wait_reg && b_reg == '0)
                begin
                    state_next = S_DIV_RN;
                end
            end
            S_DIV_RN:  if (wait_reg && div_rsp.done) state_next = S_DIV_RD;
            S_DIV_RD:  if (wait_reg && div_rsp.done) state_next = S_DONE;
            S_DONE:    state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    // Unit commands. A divide is issued in a divide state and then awaited; the gcd states issue one per Euclid step.
    always_comb
    begin
        div_cmd.start    = 1'b0;
        div_cmd.dividend = a_reg;
        div_cmd.divisor  = b_reg;
        mul_a            = q1_reg;
        mul_b            = d2_reg;
        wait_next        = wait_reg;
        unique case (state_reg)
            S_DIV_Q1:
            begin
                div_cmd.dividend = SUM_W'(d1_reg);
                div_cmd.divisor  = a_reg;
            end
            S_DIV_S1:
            begin
                div_cmd.dividend = SUM_W'(d2_reg);
                div_cmd.divisor  = a_reg;
            end
            S_DIV_W:
            begin
                div_cmd.dividend = rn_reg;
                div_cmd.divisor  = rd_reg;
            end
            S_DIV_RN:
            begin
                div_cmd.dividend = rn_reg;
                div_cmd.divisor  = a_reg;
            end
            S_DIV_RD:
            begin
                div_cmd.dividend = rd_reg;
                div_cmd.divisor  = a_reg;
            end
            S_MUL_XL:
            begin
                mul_a = n1_reg;
                mul_b = s1_reg;
            end
            S_MUL_XR:
            begin
                mul_a = n2_reg;
                mul_b = q1_reg;
            end
            S_MUL_N:
            begin
                mul_a = n1_reg;
                mul_b = n2_reg;
            end
            S_MUL_D:
            begin
                mul_a = d1_reg;
                mul_b = d2_reg;
            end
            default:
            begin
            end
        endcase
        if (div_state)
        begin
            if (!wait_reg)
            begin
                // The gcd loops end without a divide once the remainder is zero.
                if (!((state_reg == S_GCD_D || state_reg == S_GCD_R) && b_reg == '0))
                begin
                    div_cmd.start = 1'b1;
                    wait_next     = 1'b1;
                end
            end
            else if (div_rsp.done)
            begin
                wait_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            wait_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            wait_reg  <= wait_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            n1_reg  <= in_n1;
            d1_reg  <= in_d1;
            n2_reg  <= in_n2;
            d2_reg  <= in_d2;
            a_reg   <= SUM_W'(in_d1);
            b_reg   <= SUM_W'(in_d2);
            exl_reg <= '0;
            exr_reg <= '0;
            rn_reg  <= SUM_W'(in_n1);
            rd_reg  <= SUM_W'(in_d1);
        end
        else
        begin
            unique case (state_reg)
                S_GCD_D, S_GCD_R:
                begin
                    if (wait_reg && div_rsp.done)
                    begin
                        a_reg <= b_reg;
                        b_reg <= div_rsp.rem;
                    end
                end
                S_DIV_Q1: if (wait_reg && div_rsp.done) q1_reg <= OPERAND_BITS'(div_rsp.quot);
                S_DIV_S1: if (wait_reg && div_rsp.done) s1_reg <= OPERAND_BITS'(div_rsp.quot);
                S_MUL_XL: l_reg <= mul_p;
                S_MUL_XR: exl_reg <= mul_p;
                S_ADD_SUM:
                begin
                    exr_reg <= mul_p;
                    rn_reg  <= SUM_W'(exl_reg) + SUM_W'(mul_p);
                    rd_reg  <= (l_reg == '0) ? SUM_W'(1) : SUM_W'(l_reg);
                end
                S_MUL_D: rn_reg <= SUM_W'(mul_p);
                S_MUL_FIN: rd_reg <= (mul_p == '0) ? SUM_W'(1) : SUM_W'(mul_p);
                S_DIV_W:
                begin
                    if (wait_reg && div_rsp.done)
                    begin
                        if (div_rsp.rem == '0)
                        begin
                            whole_reg <= 1'b1;
                            qn_reg    <= div_rsp.quot;
                            qd_reg    <= SUM_W'(1);
                        end
                        else
                        begin
                            // gcd(rn, rd) equals gcd(rd, rn mod rd).
                            whole_reg <= 1'b0;
                            a_reg     <= rd_reg;
                            b_reg     <= div_rsp.rem;
                        end
                    end
                end
                S_DIV_RN: if (wait_reg && div_rsp.done) qn_reg <= div_rsp.quot;
                S_DIV_RD: if (wait_reg && div_rsp.done) qd_reg <= div_rsp.quot;
                default:
                begin
                end
            endcase
        end
    end

    assign done                       = (state_reg == S_DONE);
    assign result.expanded_left       = WIDE_W'(exl_reg);
    assign result.expanded_right      = WIDE_W'(exr_reg);
    assign result.raw_numerator       = WIDER_W'(rn_reg);
    assign result.raw_denominator     = WIDE_W'(rd_reg);
    assign result.reduced_numerator   = WIDER_W'(qn_reg);
    assign result.reduced_denominator = WIDE_W'(qd_reg);
    assign result.is_whole            = whole_reg;

endmodule

// File: design/fam_check.sv
// Port-level checks on the fraction unit's request and result behavior.
// Depends on fam_pkg; bound to fraction_add_multiply_reduce_top at the end of this file.
module fam_check (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input fam_pkg::fam_req_t request,
    input logic              busy,
    input logic              done,
    input fam_pkg::fam_res_t result
);
    import fam_pkg::*;

    logic unused_req;
    assign unused_req = ^request;

    // An accepted request holds the unit busy on the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted but unit not busy");

    // A result only appears while a request is in flight.
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result strobe without a request in flight");

    // The unit is free again right after a result.
    a_done_free: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> (!busy && !done))
        else $error("unit still busy after its result");

    // A whole result is reduced to a denominator of one.
    a_whole_den: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.is_whole) |-> (result.reduced_denominator == WIDE_W'(1)))
        else $error("whole result with denominator other than one");

endmodule

bind fraction_add_multiply_reduce_top fam_check u_fam_check (.*);

// File: tb/fraction_add_multiply_reduce_top_tb.sv
// Self-checking testbench for the exact fraction unit: directed fractions, then random requests.
// A local predictor models simplify, multiply and add with gcd reduction in 64-bit arithmetic.
// Depends on fam_pkg and fraction_add_multiply_reduce_top.
`timescale 1ns / 100ps

module fraction_add_multiply_reduce_top_tb;
    import fam_pkg::*;

    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 11;
    localparam int MAX_REPORTS    = 10;
    localparam int DRAIN_CYCLES   = 3000;
    localparam int CYCLE_LIMIT    = 15_000_000;

    logic     clk = 1'b0;
    logic     rst_n;
    logic     start;
    fam_req_t request;
    logic     busy;
    logic     done;
    fam_res_t result;

    fam_res_t expected_fractions[$];
    int       sender_idle_pct;
    int       mismatches;
    int       results_checked;
    int       whole_results;
    int       op_counts[4];
    longint   cycle_count = 0;

    fraction_add_multiply_reduce_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .request(request),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    always #CLK_HALF clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_count, expected_fractions.size());
            $display("Verification failed");
            $finish;
        end
    end

    function automatic logic [63:0] euclid_gcd(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] t;
        while (b != 64'd0)
        begin
            t = a % b;
            a = b;
            b = t;
        end
        return a;
    endfunction

    function automatic fam_res_t predict_fraction(input fam_req_t r);
        logic [63:0] mask;
        logic [63:0] n1, d1, n2, d2;
        logic [63:0] exl, exr, rn, rd, g, l, qn, qd;
        logic        whole;
        fam_res_t    res;
        mask = (64'd1 << OPERAND_BITS) - 64'd1;
        n1   = {48'd0, r.num1} & mask;
        d1   = {48'd0, r.den1} & mask;
        n2   = {48'd0, r.num2} & mask;
        d2   = {48'd0, r.den2} & mask;
        exl  = 64'd0;
        exr  = 64'd0;
        // A zero denominator is read as one.
        if (d1 == 64'd0) d1 = 64'd1;
        if (d2 == 64'd0) d2 = 64'd1;
        case (r.req_type)
            REQ_SIMPLIFY:
            begin
                rn = n1;
                rd = d1;
            end
            REQ_MULTIPLY:
            begin
                rn = n1 * n2;
                rd = d1 * d2;
            end
            default:
            begin
                g   = euclid_gcd(d1, d2);
                l   = (d1 / g) * d2;
                exl = n1 * (l / d1);
                exr = n2 * (l / d2);
                rn  = exl + exr;
                rd  = l;
            end
        endcase
        if (rd == 64'd0) rd = 64'd1;
        if (rn % rd == 64'd0)
        begin
            whole = 1'b1;
            qn    = rn / rd;
            qd    = 64'd1;
        end
        else
        begin
            g     = euclid_gcd(rn, rd);
            whole = 1'b0;
            qn    = rn / g;
            qd    = rd / g;
        end
        res.expanded_left       = exl[WIDE_W-1:0];
        res.expanded_right      = exr[WIDE_W-1:0];
        res.raw_numerator       = rn[WIDER_W-1:0];
        res.raw_denominator     = rd[WIDE_W-1:0];
        res.reduced_numerator   = qn[WIDER_W-1:0];
        res.reduced_denominator = qd[WIDE_W-1:0];
        res.is_whole            = whole;
        return res;
    endfunction

    // Results are sampled mid-cycle, away from the edge where the block updates them.
    always @(negedge clk)
    begin
        fam_res_t want;
        logic     bad;
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            if (expected_fractions.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: result with no request outstanding: %p", $realtime, result);
            end
            else
            begin
                want = expected_fractions.pop_front();
                bad  = (result.expanded_left       !== want.expanded_left)       ||
                       (result.expanded_right      !== want.expanded_right)      ||
                       (result.raw_numerator       !== want.raw_numerator)       ||
                       (result.raw_denominator     !== want.raw_denominator)     ||
                       (result.reduced_numerator   !== want.reduced_numerator)   ||
                       (result.reduced_denominator !== want.reduced_denominator) ||
                       (result.is_whole            !== want.is_whole);
                results_checked++;
                if (bad)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                    begin
                        $display("%0t: mismatch on result %0d", $realtime, results_checked);
                        $display("  expected exl=%0d exr=%0d raw=%0d/%0d reduced=%0d/%0d whole=%0b",
                                 want.expanded_left, want.expanded_right,
                                 want.raw_numerator, want.raw_denominator,
                                 want.reduced_numerator, want.reduced_denominator,
                                 want.is_whole);
                        $display("  actual   exl=%0d exr=%0d raw=%0d/%0d reduced=%0d/%0d whole=%0b",
                                 result.expanded_left, result.expanded_right,
                                 result.raw_numerator, result.raw_denominator,
                                 result.reduced_numerator, result.reduced_denominator,
                                 result.is_whole);
                    end
                end
                else if (result.is_whole)
                begin
                    whole_results++;
                end
            end
        end
    end

    function automatic fam_req_t make_fraction_req(input req_type_t op,
                                                   input logic [15:0] n1, input logic [15:0] d1,
                                                   input logic [15:0] n2, input logic [15:0] d2);
        fam_req_t r;
        r.req_type = op;
        r.num1     = n1;
        r.den1     = d1;
        r.num2     = n2;
        r.den2     = d2;
        return r;
    endfunction

    function automatic logic [15:0] pick_operand(input bit is_den);
        logic [31:0] prod;
        case ($urandom_range(0, 9))
            0:       return (is_den && $urandom_range(0, 3) != 0) ? 16'd1 : 16'd0;
            1, 2, 3: return 16'($urandom_range(1, 16));
            4:       return 16'hFFFF - 16'($urandom_range(0, 3));
            5, 6:
            begin
                // Products of small factors give plenty of common divisors.
                prod = $urandom_range(1, 255) * $urandom_range(1, 255);
                return prod[15:0];
            end
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic fam_req_t random_fraction_req();
        fam_req_t    r;
        logic [31:0] scaled;
        int          sel;
        sel = $urandom_range(0, 19);
        if (sel < 6)
            r.req_type = REQ_SIMPLIFY;
        else if (sel < 12)
            r.req_type = REQ_MULTIPLY;
        else if (sel < 18)
            r.req_type = REQ_ADD;
        else
            r.req_type = REQ_ADD_ALT;
        r.num1 = pick_operand(1'b0);
        r.den1 = pick_operand(1'b1);
        r.num2 = pick_operand(1'b0);
        r.den2 = pick_operand(1'b1);
        // Now and then make the first fraction a whole number.
        if ($urandom_range(0, 9) == 0)
        begin
            scaled = r.den1 * $urandom_range(0, 7);
            r.num1 = scaled[15:0];
        end
        return r;
    endfunction

    // Called just after a rising edge; returns just after the edge that takes the request.
    // Each cycle before the request is shown, the sender idles with the set percentage.
    task automatic issue_request(input fam_req_t req);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start   <= 1'b1;
        request <= req;
        @(negedge clk);
        while (busy !== 1'b0)
        begin
            @(posedge clk);
            @(negedge clk);
        end
        expected_fractions.push_back(predict_fraction(req));
        op_counts[req.req_type]++;
        @(posedge clk);
    endtask

    task automatic wait_for_results();
        start <= 1'b0;
        @(posedge clk);
        while (expected_fractions.size() != 0) @(posedge clk);
    endtask

    task automatic run_random_batch(input int count);
        for (int i = 0; i < count; i++)
        begin
            issue_request(random_fraction_req());
            if ($urandom_range(0, 49) == 0) wait_for_results();
        end
        wait_for_results();
    endtask

    task automatic test_directed_cases();
        sender_idle_pct = 0;
        issue_request(make_fraction_req(REQ_SIMPLIFY, 16'd0,     16'd1,     16'd0,     16'd1));
        issue_request(make_fraction_req(REQ_SIMPLIFY, 16'hFFFF,  16'hFFFF,  16'd0,     16'd1));
        issue_request(make_fraction_req(REQ_SIMPLIFY, 16'hFFFF,  16'd1,     16'd3,     16'd5));
        issue_request(make_fraction_req(REQ_SIMPLIFY, 16'd0,     16'hFFFF,  16'hFFFF,  16'hFFFF));
        issue_request(make_fraction_req(REQ_SIMPLIFY, 16'd12,    16'd0,     16'd0,     16'd0));
        issue_request(make_fraction_req(REQ_SIMPLIFY, 16'd46368, 16'd28657, 16'd1,     16'd1));
        issue_request(make_fraction_req(REQ_SIMPLIFY, 16'd60,    16'd48,    16'hAAAA,  16'h5555));
        issue_request(make_fraction_req(REQ_MULTIPLY, 16'hFFFF,  16'hFFFF,  16'hFFFF,  16'hFFFF));
        issue_request(make_fraction_req(REQ_MULTIPLY, 16'd0,     16'd7,     16'd5,     16'd3));
        issue_request(make_fraction_req(REQ_MULTIPLY, 16'd2,     16'd3,     16'd3,     16'd2));
        issue_request(make_fraction_req(REQ_MULTIPLY, 16'd7,     16'd0,     16'd5,     16'd0));
        issue_request(make_fraction_req(REQ_MULTIPLY, 16'hFFFF,  16'd1,     16'hFFFF,  16'd1));
        issue_request(make_fraction_req(REQ_MULTIPLY, 16'd3,     16'd65521, 16'd5,     16'd65519));
        issue_request(make_fraction_req(REQ_ADD,      16'd1,     16'd2,     16'd1,     16'd2));
        issue_request(make_fraction_req(REQ_ADD,      16'hFFFF,  16'hFFFF,  16'hFFFF,  16'hFFFE));
        issue_request(make_fraction_req(REQ_ADD,      16'hFFFF,  16'd65521, 16'hFFFF,  16'd65519));
        issue_request(make_fraction_req(REQ_ADD,      16'd0,     16'd5,     16'd0,     16'd7));
        issue_request(make_fraction_req(REQ_ADD,      16'd5,     16'd0,     16'd3,     16'd0));
        issue_request(make_fraction_req(REQ_ADD,      16'd1,     16'd6,     16'd1,     16'd10));
        issue_request(make_fraction_req(REQ_ADD_ALT,  16'd1,     16'd3,     16'd1,     16'd6));
        issue_request(make_fraction_req(REQ_ADD_ALT,  16'hFFFF,  16'hFFFF,  16'd0,     16'd1));
        issue_request(make_fraction_req(REQ_ADD,      16'hFFFF,  16'd1,     16'hFFFF,  16'd1));
        issue_request(make_fraction_req(REQ_ADD,      16'd46368, 16'd28657, 16'd28657, 16'd46368));
        wait_for_results();
    endtask

    task automatic test_sparse_sender_gaps();
        sender_idle_pct = 9;
        run_random_batch(380);
    endtask

    task automatic test_frequent_sender_gaps();
        sender_idle_pct = 69;
        run_random_batch(380);
    endtask

    task automatic test_back_to_back();
        sender_idle_pct = 0;
        run_random_batch(390);
    endtask

    initial
    begin
        rst_n           <= 1'b0;
        start           <= 1'b0;
        request         <= '0;
        mismatches      = 0;
        results_checked = 0;
        whole_results   = 0;
        sender_idle_pct = 0;
        foreach (op_counts[i]) op_counts[i] = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_sparse_sender_gaps();
        test_frequent_sender_gaps();
        test_back_to_back();

        // Any stray strobe after the last expected result is still caught here.
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_fractions.size() != 0)
        begin
            $display("%0d expected results never arrived", expected_fractions.size());
            mismatches += expected_fractions.size();
        end

        $display("Checked %0d results: %0d simplify, %0d multiply, %0d add, %0d alternate add code",
                 results_checked, op_counts[REQ_SIMPLIFY], op_counts[REQ_MULTIPLY],
                 op_counts[REQ_ADD], op_counts[REQ_ADD_ALT]);
        $display("%0d results were whole numbers; %0d mismatches in %0d cycles",
                 whole_results, mismatches, cycle_count);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// File: filelist.f
design/fam_pkg.sv
design/fam_div.sv
design/fam_mul.sv
design/fraction_add_multiply_reduce_top.sv
design/fam_check.sv
tb/fraction_add_multiply_reduce_top_tb.sv
